FILE: src/rlbd_pkg.sv
// Shared constants, codes and word types of the raster line and box draw unit.
package rlbd_pkg;

    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 256;
    localparam int CMD_DEPTH       = 2;
    localparam int RES_DEPTH       = 2;

    localparam int CFG_W       = 9;
    localparam int REG_INDEX_W = 1;
    localparam logic [REG_INDEX_W-1:0] REG_COLUMNS = 1'd0;
    localparam logic [REG_INDEX_W-1:0] REG_ROWS    = 1'd1;
    localparam logic [CFG_W-1:0]       DIM_RESET   = 9'd256;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_BOX   = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [1:0] OP_NOP  = 2'd0;
    localparam logic [1:0] OP_FILL = 2'd1;
    localparam logic [1:0] OP_LINE = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [7:0] VALUE_BLANK = 8'hFF;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;
        logic       status;
        logic       has_content;
    } cmd_meta_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       status;
        logic       has_content;
    } result_t;

endpackage

FILE: src/rlbd_fifo.sv
// Small first-in first-out queue built from registers.
module rlbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    as_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count exceeds depth");

    as_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

    as_pop_pointer: assert property (@(posedge clk) disable iff (!rst_n)
        !do_pop |=> rd_ptr_reg == $past(rd_ptr_reg))
        else $error("read pointer moved without a pop");

endmodule

FILE: src/rlbd_front.sv
// Command front end: size registers, command checks, clipping and the content flag.
module rlbd_front #(
    parameter int MAX_COLUMNS = rlbd_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = rlbd_pkg::DEF_MAX_ROWS,
    parameter int CW          = $clog2(MAX_COLUMNS),
    parameter int RW          = $clog2(MAX_ROWS)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rlbd_pkg::REG_INDEX_W-1:0]   cfg_index,
    input  logic [rlbd_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               push,
    input  logic                               cmd_full,
    input  logic [1:0]                         kind,
    input  logic signed [15:0]                 x_start,
    input  logic signed [15:0]                 y_start,
    input  logic signed [15:0]                 x_end,
    input  logic signed [15:0]                 y_end,
    input  logic [9:0]                         half_size,
    input  logic [7:0]                         pixel_value,
    output logic                               cmd_push,
    output rlbd_pkg::cmd_meta_t                cmd_meta,
    output logic [2*(CW+RW)-1:0]               cmd_coords
);
    import rlbd_pkg::*;

    logic [CFG_W-1:0]   columns_reg, columns_next;
    logic [CFG_W-1:0]   rows_reg, rows_next;
    logic               content_reg, content_next;
    logic signed [17:0] col_lim, row_lim, col_last, row_last;
    logic signed [17:0] xs, ys, xe, ye, hs;
    logic signed [17:0] bx0, bx1, by0, by1, bx0c, bx1c, by0c, by1c;
    logic signed [17:0] px0, py0, px1, py1;
    logic               in_start, in_end, box_empty;
    logic [1:0]         op;
    logic               status;

    assign xs = 18'(x_start);
    assign ys = 18'(y_start);
    assign xe = 18'(x_end);
    assign ye = 18'(y_end);
    assign hs = signed'({8'b0, half_size});

    assign col_lim = (columns_reg == '0) ? 18'sd1 :
                     (18'(columns_reg) > 18'(MAX_COLUMNS)) ? signed'(18'(MAX_COLUMNS)) :
                     signed'(18'(columns_reg));
    assign row_lim = (rows_reg == '0) ? 18'sd1 :
                     (18'(rows_reg) > 18'(MAX_ROWS)) ? signed'(18'(MAX_ROWS)) :
                     signed'(18'(rows_reg));
    assign col_last = col_lim - 18'sd1;
    assign row_last = row_lim - 18'sd1;

    assign in_start = (xs >= 18'sd0) && (xs <= col_last) && (ys >= 18'sd0) && (ys <= row_last);
    assign in_end   = (xe >= 18'sd0) && (xe <= col_last) && (ye >= 18'sd0) && (ye <= row_last);

    assign bx0  = xs - hs;
    assign bx1  = xs + hs;
    assign by0  = ys - hs;
    assign by1  = ys + hs;
    assign bx0c = (bx0 < 18'sd0) ? 18'sd0 : bx0;
    assign bx1c = (bx1 > col_last) ? col_last : bx1;
    assign by0c = (by0 < 18'sd0) ? 18'sd0 : by0;
    assign by1c = (by1 > row_last) ? row_last : by1;
    assign box_empty = (bx0c > bx1c) || (by0c > by1c);

    always_comb
    begin
        op           = OP_NOP;
        status       = 1'b0;
        content_next = content_reg;
        px0          = xs;
        py0          = ys;
        px1          = xe;
        py1          = ye;
        case (kind)
            KIND_CLEAR:
            begin
                op           = OP_FILL;
                px0          = 18'sd0;
                py0          = 18'sd0;
                px1          = col_last;
                py1          = row_last;
                content_next = (pixel_value != VALUE_BLANK);
            end
            KIND_LINE:
            begin
                if (in_start && in_end)
                begin
                    op           = OP_LINE;
                    content_next = 1'b1;
                end
                else
                begin
                    status = 1'b1;
                end
            end
            KIND_BOX:
            begin
                if (half_size > 10'd1)
                begin
                    op           = box_empty ? OP_NOP : OP_FILL;
                    px0          = bx0c;
                    py0          = by0c;
                    px1          = bx1c;
                    py1          = by1c;
                    content_next = 1'b1;
                end
                else if (in_start)
                begin
                    op           = OP_FILL;
                    px1          = xs;
                    py1          = ys;
                    content_next = 1'b1;
                end
                else
                begin
                    status = 1'b1;
                end
            end
            KIND_READ:
            begin
                if (in_start)
                begin
                    op = OP_READ;
                end
                else
                begin
                    status = 1'b1;
                end
            end
            default:
            begin
                op = OP_NOP;
            end
        endcase
    end

    assign cmd_push = push && !cmd_full;

    assign cmd_meta.op          = op;
    assign cmd_meta.value       = pixel_value;
    assign cmd_meta.status      = status;
    assign cmd_meta.has_content = content_next;
    assign cmd_coords = {px0[CW-1:0], py0[RW-1:0], px1[CW-1:0], py1[RW-1:0]};

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMNS: columns_next = cfg_data;
                REG_ROWS:    rows_next    = cfg_data;
                default:     columns_next = columns_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= DIM_RESET;
            rows_reg    <= DIM_RESET;
            content_reg <= 1'b0;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
            if (cmd_push)
            begin
                content_reg <= content_next;
            end
        end
    end

    as_reject_keeps_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && status) |=> content_reg == $past(content_reg))
        else $error("a rejected command changed the content flag");

    as_blank_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && kind == KIND_CLEAR && pixel_value == VALUE_BLANK) |=> !content_reg)
        else $error("clearing with the blank value left the content flag set");

    as_fill_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && op == OP_FILL) |-> (px1 <= col_last) && (py1 <= row_last) &&
                                        (px0 >= 18'sd0) && (py0 >= 18'sd0))
        else $error("fill rectangle reaches outside the area in use");

endmodule

FILE: src/rlbd_back.sv
// Drawing back end: pixel store, rectangle scan, line walk, pixel read and result build.
module rlbd_back #(
    parameter int MAX_COLUMNS = rlbd_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = rlbd_pkg::DEF_MAX_ROWS,
    parameter int CW          = $clog2(MAX_COLUMNS),
    parameter int RW          = $clog2(MAX_ROWS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_empty,
    input  rlbd_pkg::cmd_meta_t  cmd_meta,
    input  logic [2*(CW+RW)-1:0] cmd_coords,
    output logic                 cmd_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output rlbd_pkg::result_t    res_word
);
    import rlbd_pkg::*;

    localparam int MW        = (CW > RW) ? CW : RW;
    localparam int EW        = MW + 3;
    localparam int AW        = CW + RW;
    localparam int MEM_DEPTH = 1 << AW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_LINE = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [7:0]          pixel_mem [MEM_DEPTH];
    logic [7:0]          rd_data_reg;

    logic [2:0]          state_reg, state_next;
    cmd_meta_t           meta_reg, meta_next;
    logic [CW-1:0]       cx_reg, cx_next, ex_reg, ex_next;
    logic [RW-1:0]       cy_reg, cy_next, ey_reg, ey_next, ybase_reg, ybase_next;
    logic signed [EW-1:0] err_reg, err_next, dx_reg, dx_next, dy_reg, dy_next;
    logic                sxn_reg, sxn_next, syn_reg, syn_next;

    logic [CW-1:0]       c_x0, c_x1;
    logic [RW-1:0]       c_y0, c_y1;
    logic signed [EW-1:0] fx0, fx1, fy0, fy1, dx_init, dy_init;
    logic signed [EW:0]  e2, err_sum;
    logic                step_x, step_y, at_end, mem_we;
    logic [AW-1:0]       mem_addr;

    assign {c_x0, c_y0, c_x1, c_y1} = cmd_coords;
    assign fx0 = signed'(EW'(c_x0));
    assign fx1 = signed'(EW'(c_x1));
    assign fy0 = signed'(EW'(c_y0));
    assign fy1 = signed'(EW'(c_y1));
    assign dx_init = (fx1 > fx0) ? fx1 - fx0 : fx0 - fx1;
    assign dy_init = (fy1 > fy0) ? fy0 - fy1 : fy1 - fy0;

    assign at_end  = (cx_reg == ex_reg) && (cy_reg == ey_reg);
    assign e2      = {err_reg, 1'b0};
    assign step_x  = (e2 >= (EW+1)'(dy_reg));
    assign step_y  = (e2 <= (EW+1)'(dx_reg));
    assign err_sum = (EW+1)'(err_reg) + (step_x ? (EW+1)'(dy_reg) : '0)
                                      + (step_y ? (EW+1)'(dx_reg) : '0);

    assign mem_addr = {cx_reg, cy_reg};
    assign mem_we   = (state_reg == S_FILL) || (state_reg == S_LINE);

    always_comb
    begin
        state_next = state_reg;
        meta_next  = meta_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        ybase_next = ybase_reg;
        err_next   = err_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sxn_next   = sxn_reg;
        syn_next   = syn_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    meta_next  = cmd_meta;
                    cx_next    = c_x0;
                    cy_next    = c_y0;
                    ex_next    = c_x1;
                    ey_next    = c_y1;
                    ybase_next = c_y0;
                    dx_next    = dx_init;
                    dy_next    = dy_init;
                    err_next   = dx_init + dy_init;
                    sxn_next   = !(c_x0 < c_x1);
                    syn_next   = !(c_y0 < c_y1);
                    case (cmd_meta.op)
                        OP_FILL: state_next = S_FILL;
                        OP_LINE: state_next = S_LINE;
                        OP_READ: state_next = S_READ;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_FILL:
            begin
                if (cy_reg == ey_reg)
                begin
                    cy_next = ybase_reg;
                    if (cx_reg == ex_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cx_next = cx_reg + 1'b1;
                    end
                end
                else
                begin
                    cy_next = cy_reg + 1'b1;
                end
            end
            S_LINE:
            begin
                if (at_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    err_next = err_sum[EW-1:0];
                    if (step_x)
                    begin
                        cx_next = sxn_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
                    end
                    if (step_y)
                    begin
                        cy_next = syn_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_word.read_value  = (meta_reg.op == OP_READ) ? rd_data_reg : 8'd0;
    assign res_word.status      = meta_reg.status;
    assign res_word.has_content = meta_reg.has_content;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg  <= meta_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        ybase_reg <= ybase_next;
        err_reg   <= err_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sxn_reg   <= sxn_next;
        syn_reg   <= syn_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pixel_mem[mem_addr] <= meta_reg.value;
        end
        rd_data_reg <= pixel_mem[mem_addr];
    end

    as_line_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINE && !at_end) |-> (step_x || step_y))
        else $error("line walk stalled before its end point");

    as_line_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINE && at_end) |=> state_reg == S_DONE)
        else $error("line walk passed its end point");

    as_read_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_DONE) && $stable(mem_addr))
        else $error("pixel read did not settle before the result");

endmodule

FILE: src/raster_line_and_box_draw_unit.sv
// Top level of the raster line and box draw unit: front end, command queue, back end, result queue.
//
//  Channel   | Signals                                              | Transfer
//  ----------+------------------------------------------------------+---------------------------
//  command   | push, full, kind, x/y_start, x/y_end, half_size,     | push && !full
//            | pixel_value                                          |
//  result    | empty, pop, read_value, status, has_content          | pop && !empty
//  config    | cfg_we, cfg_index, cfg_data                          | cfg_we
//
// A word is checked and clipped as it is pushed and waits in a two-entry command queue.
// The back end writes one pixel per cycle into its single-port pixel memory while it fills or
// walks a line: a clear fills the whole area in use, a line each pixel of its walk, a box each
// clipped pixel. A read and a rejected word write no pixel and only build a result.
// Reset clears control state only; the pixel memory holds nothing defined until drawn.
// Results wait in a two-entry queue; a full result queue stalls the back end, which then pops no commands.
module raster_line_and_box_draw_unit #(
    parameter int MAX_COLUMNS = rlbd_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = rlbd_pkg::DEF_MAX_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rlbd_pkg::REG_INDEX_W-1:0] cfg_index,
    input  logic [rlbd_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       kind,
    input  logic signed [15:0]               x_start,
    input  logic signed [15:0]               y_start,
    input  logic signed [15:0]               x_end,
    input  logic signed [15:0]               y_end,
    input  logic [9:0]                       half_size,
    input  logic [7:0]                       pixel_value,
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       read_value,
    output logic                             status,
    output logic                             has_content
);
    import rlbd_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CRD_W = 2 * (CW + RW);
    localparam int CMD_W = $bits(cmd_meta_t) + CRD_W;

    logic             cmd_push, cmd_pop, cmd_full, cmd_empty;
    cmd_meta_t        front_meta, back_meta;
    logic [CRD_W-1:0] front_coords, back_coords;
    logic             res_push, res_full;
    result_t          back_res, out_res;

    rlbd_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .CW          (CW),
        .RW          (RW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .cmd_full    (cmd_full),
        .kind        (kind),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .half_size   (half_size),
        .pixel_value (pixel_value),
        .cmd_push    (cmd_push),
        .cmd_meta    (front_meta),
        .cmd_coords  (front_coords)
    );

    rlbd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data ({front_meta, front_coords}),
        .pop       (cmd_pop),
        .pop_data  ({back_meta, back_coords}),
        .full      (cmd_full),
        .empty     (cmd_empty)
    );

    rlbd_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .CW          (CW),
        .RW          (RW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_meta   (back_meta),
        .cmd_coords (back_coords),
        .cmd_pop    (cmd_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_word   (back_res)
    );

    rlbd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (back_res),
        .pop       (pop),
        .pop_data  (out_res),
        .full      (res_full),
        .empty     (empty)
    );

    assign full        = cmd_full;
    assign read_value  = out_res.read_value;
    assign status      = out_res.status;
    assign has_content = out_res.has_content;

endmodule
